// File: hw/rtl/aes_kx_pkg.sv
// Shared types, constants and functions of the AES-128 key expansion block.
`timescale 1ns / 1ps
`default_nettype none

package aes_kx_pkg;

    // Key format and schedule length.
    localparam logic [5:0] KEY_BYTES   = 6'd16;
    localparam int         NUM_ROUNDS  = 11;
    localparam logic [3:0] LAST_ROUND  = 4'(NUM_ROUNDS - 1);
    localparam logic [8:0] GF_POLY     = 9'h11b;
    localparam logic [7:0] RC_INIT     = 8'h01;
    localparam int         QUEUE_DEPTH = 2;

    // One input beat: a key and its stated length.
    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [5:0]  key_length;
    } t_key_beat;

    // One result beat: a round key or an error marker.
    typedef struct packed {
        logic [3:0]  round_index;
        logic [63:0] round_key_high;
        logic [63:0] round_key_low;
        logic        status;
        logic        last;
    } t_round_beat;

    // A classified job as it waits between front and back.
    typedef struct packed {
        logic [127:0] key;
        logic         err;
    } t_job;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8) modulo the AES polynomial.
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY[7:0] : 8'h00);
    endfunction

    // Rotate a word left by one byte, then substitute every byte.
    function automatic logic [31:0] sub_rot_word(input logic [31:0] w);
        return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

    // Derive the next round key from the previous one.
    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0]   rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = sub_rot_word(k[31:0]) ^ {rc, 24'h000000};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aes_kx_stream_if.sv
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface aes_kx_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/aes_kx_front.sv
// Front stage: takes key beats, checks the length and registers a job.
`timescale 1ns / 1ps
`default_nettype none

module aes_kx_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    aes_kx_stream_if.sink   i_key,
    aes_kx_stream_if.source o_job
);

    logic               r_valid;
    logic               n_valid;
    aes_kx_pkg::t_job   r_job;
    aes_kx_pkg::t_job   n_job;
    logic               w_take;
    logic               w_bad_len;

    // The stage can take a beat whenever it is empty or its job leaves now.
    assign i_key.ready = !r_valid || o_job.ready;
    assign w_take      = i_key.valid && i_key.ready;
    assign w_bad_len   = (i_key.data.key_length != aes_kx_pkg::KEY_BYTES);

    // Classify the beat; a rejected key carries zeros onward.
    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (w_take) begin
            n_valid     = 1'b1;
            n_job.err   = w_bad_len;
            n_job.key   = w_bad_len ? 128'd0 : {i_key.data.key_high, i_key.data.key_low};
        end else if (o_job.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

    assign o_job.valid = r_valid;
    assign o_job.data  = r_job;

endmodule

`default_nettype wire

// File: hw/rtl/aes_kx_queue.sv
// Short job queue that decouples the front stage from the expansion engine.
`timescale 1ns / 1ps
`default_nettype none

module aes_kx_queue #(
    parameter int DEPTH = aes_kx_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    aes_kx_stream_if.sink   i_job,
    aes_kx_stream_if.source o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aes_kx_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             w_push;
    logic             w_pop;

    assign i_job.ready = (r_count != CW'(DEPTH));
    assign o_job.valid = (r_count != '0);
    assign o_job.data  = r_mem[r_rd_ptr];
    assign w_push      = i_job.valid && i_job.ready;
    assign w_pop       = o_job.valid && o_job.ready;

    // Pointer and fill-count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job.data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/aes_kx_back.sv
// Expansion engine: produces one round key per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module aes_kx_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    aes_kx_stream_if.sink   i_job,
    aes_kx_stream_if.source o_round
);

    logic                    r_valid;
    logic                    n_valid;
    aes_kx_pkg::t_round_beat r_beat;
    aes_kx_pkg::t_round_beat n_beat;
    logic [7:0]              r_rc;
    logic [7:0]              n_rc;
    logic                    w_load;
    logic                    w_mid_key;
    logic [127:0]            w_next_key;
    logic [3:0]              w_next_idx;

    // The output register may change when it is empty or its beat is taken.
    assign w_load      = !r_valid || o_round.ready;
    // A key is still being expanded while the held beat is not its last.
    assign w_mid_key   = r_valid && !r_beat.last;
    assign i_job.ready = w_load && !w_mid_key;

    assign w_next_key = aes_kx_pkg::next_round_key({r_beat.round_key_high,
                                                    r_beat.round_key_low}, r_rc);
    assign w_next_idx = r_beat.round_index + 4'd1;

    // Either advance the current key by one round or start the next job.
    always_comb begin
        n_valid = r_valid;
        n_beat  = r_beat;
        n_rc    = r_rc;
        if (w_load) begin
            if (w_mid_key) begin
                n_valid               = 1'b1;
                n_beat.round_index    = w_next_idx;
                n_beat.round_key_high = w_next_key[127:64];
                n_beat.round_key_low  = w_next_key[63:0];
                n_beat.status         = 1'b0;
                n_beat.last           = (w_next_idx == aes_kx_pkg::LAST_ROUND);
                n_rc                  = aes_kx_pkg::xtime(r_rc);
            end else begin
                n_valid               = i_job.valid;
                n_beat.round_index    = 4'd0;
                n_beat.round_key_high = i_job.data.key[127:64];
                n_beat.round_key_low  = i_job.data.key[63:0];
                n_beat.status         = i_job.data.err;
                n_beat.last           = i_job.data.err;
                n_rc                  = aes_kx_pkg::RC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_beat <= n_beat;
        r_rc   <= n_rc;
    end

    assign o_round.valid = r_valid;
    assign o_round.data  = r_beat;

endmodule

`default_nettype wire

// File: hw/rtl/aes128_key_expansion.sv
// Top level of the AES-128 key expansion block.
`timescale 1ns / 1ps
`default_nettype none

// A key beat with a stated length of 16 bytes yields eleven round-key beats,
// rounds 0 to 10 in order, with last set on round 10; any other length yields
// one beat with status 1, zero key fields and last set. The expansion engine
// derives one round key per cycle into a single output register while the
// output is not stalled. While the engine works, keys are taken into a front
// register and a short queue (two entries by default), so the next key's
// round 0 follows the previous key's round 10 without a gap. Once both are
// full, the input stalls until the engine starts its next key. A beat taken
// into an idle block passes through the front register and a queue entry
// before its first result is held in the output register.
module aes128_key_expansion #(
    parameter int QUEUE_DEPTH = aes_kx_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    aes_kx_stream_if.sink   i_key,
    aes_kx_stream_if.source o_round
);

    aes_kx_stream_if #(.T(aes_kx_pkg::t_job)) w_front_job ();
    aes_kx_stream_if #(.T(aes_kx_pkg::t_job)) w_queue_job ();

    // Length check and registration of incoming keys.
    aes_kx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (i_key),
        .o_job   (w_front_job)
    );

    // Jobs waiting for the engine.
    aes_kx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_front_job),
        .o_job   (w_queue_job)
    );

    // Round-key generation and result register.
    aes_kx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_queue_job),
        .o_round (o_round)
    );

endmodule

`default_nettype wire
